FILE: src/cna_pkg.sv
`timescale 1ns / 1ps
// Shared definitions for the complex arithmetic unit: operation and status
// codes and default widths. No dependencies.
package cna_pkg;

  localparam int DATA_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF  = 8;

  typedef enum logic [1:0] {
    CMD_ADD = 2'd0,
    CMD_SUB = 2'd1,
    CMD_MUL = 2'd2,
    CMD_DIV = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_SAT = 2'd1,
    ST_DZ  = 2'd2
  } status_t;

endpackage

FILE: src/complex_number_alu.sv
`timescale 1ns / 1ps
// Complex add / subtract / multiply / divide on signed fixed-point pairs.
// Depends on cna_pkg for operation and status codes.
//
// One word is accepted every cycle while the result side takes words. The
// divider retires one quotient bit per pipeline stage for DATA_WIDTH + 1
// stages, behind an input register, a multiplier stage, a sum stage and a
// normalise stage, and ahead of the output register. All operations share
// the same pipeline, so results leave in input order. A stall on the result
// side holds the whole pipeline. Multiply floors the scaled products; divide
// truncates toward zero; each part saturates and flags ST_SAT, and a zero
// divisor gives zero parts with ST_DZ.
module complex_number_alu #(
  parameter int DATA_WIDTH = cna_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = cna_pkg::FRAC_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  // a_real, a_imag, b_real, b_imag from the lowest bit up, zero padded
  input  logic [((4*DATA_WIDTH+7)/8)*8-1:0]      s_tdata,
  // cmd
  input  logic [1:0]                             s_tuser,
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  // res_real, res_imag from the lowest bit up, zero padded
  output logic [((2*DATA_WIDTH+7)/8)*8-1:0]      m_tdata,
  // status
  output logic [1:0]                             m_tuser
);

  localparam int DW  = DATA_WIDTH;
  localparam int FB  = FRAC_BITS;
  localparam int PW  = 2 * DW;
  localparam int SW  = PW + 1;
  localparam int QB  = DW + 1;
  localparam int NW  = SW + FB;
  localparam int CW  = NW + QB;
  localparam int OTW = ((2*DW+7)/8)*8;

  localparam logic signed [SW-1:0] MAXP = SW'((64'sd1 <<< (DW-1)) - 64'sd1);
  localparam logic signed [SW-1:0] MINN = SW'(-(64'sd1 <<< (DW-1)));
  localparam logic [QB-1:0] QMAXP = QB'((64'd1 << (DW-1)) - 64'd1);
  localparam logic [QB-1:0] QMAXN = QB'(64'd1 << (DW-1));

  typedef struct packed {
    logic                  vld;
    cna_pkg::cmd_t         cmd;
    logic                  dz;
    logic                  sat;
    logic signed [DW-1:0]  res_re;
    logic signed [DW-1:0]  res_im;
    logic                  neg_re;
    logic                  neg_im;
    logic                  ov_re;
    logic                  ov_im;
    logic [NW-1:0]         rem_re;
    logic [NW-1:0]         rem_im;
    logic [QB-1:0]         q_re;
    logic [QB-1:0]         q_im;
    logic [PW-1:0]         den;
  } pipe_t;

  // Clamp a wide signed value to DW bits
  function automatic logic signed [DW-1:0] clamp(input logic signed [SW-1:0] v,
                                                 output logic sat);
    logic signed [DW-1:0] r;
    sat = 1'b0;
    if (v > MAXP) begin
      r   = MAXP[DW-1:0];
      sat = 1'b1;
    end else if (v < MINN) begin
      r   = MINN[DW-1:0];
      sat = 1'b1;
    end else begin
      r = v[DW-1:0];
    end
    return r;
  endfunction

  // Clamp a sign and quotient magnitude to DW bits
  function automatic logic signed [DW-1:0] clamp_q(input logic neg, input logic ov,
                                                   input logic [QB-1:0] q,
                                                   output logic sat);
    logic signed [DW-1:0] r;
    sat = 1'b0;
    if (neg) begin
      if (ov || q > QMAXN) begin
        r   = MINN[DW-1:0];
        sat = 1'b1;
      end else begin
        r = DW'(QB'(0) - q);
      end
    end else begin
      if (ov || q > QMAXP) begin
        r   = MAXP[DW-1:0];
        sat = 1'b1;
      end else begin
        r = DW'(q);
      end
    end
    return r;
  endfunction

  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // Stage 1: register the operands
  logic                 vld1;
  cna_pkg::cmd_t        cmd1;
  logic signed [DW-1:0] x1, y1, u1, w1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
    end else if (en) begin
      vld1 <= s_tvalid;
    end
    if (en) begin
      cmd1 <= cna_pkg::cmd_t'(s_tuser);
      x1   <= s_tdata[DW-1:0];
      y1   <= s_tdata[2*DW-1:DW];
      u1   <= s_tdata[3*DW-1:2*DW];
      w1   <= s_tdata[4*DW-1:3*DW];
    end
  end

  // Stage 2: products and the add / subtract sums
  logic                 vld2;
  cna_pkg::cmd_t        cmd2;
  logic signed [PW-1:0] xu, yw, yu, xw, uu, ww;
  logic signed [DW:0]   as_re, as_im;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld2 <= 1'b0;
    end else if (en) begin
      vld2 <= vld1;
    end
    if (en) begin
      cmd2 <= cmd1;
      xu   <= PW'(x1) * PW'(u1);
      yw   <= PW'(y1) * PW'(w1);
      yu   <= PW'(y1) * PW'(u1);
      xw   <= PW'(x1) * PW'(w1);
      uu   <= PW'(u1) * PW'(u1);
      ww   <= PW'(w1) * PW'(w1);
      if (cmd1 == cna_pkg::CMD_SUB) begin
        as_re <= (DW+1)'(x1) - (DW+1)'(u1);
        as_im <= (DW+1)'(y1) - (DW+1)'(w1);
      end else begin
        as_re <= (DW+1)'(x1) + (DW+1)'(u1);
        as_im <= (DW+1)'(y1) + (DW+1)'(w1);
      end
    end
  end

  // Stage 3: sum the products and the divisor
  logic                 vld3;
  cna_pkg::cmd_t        cmd3;
  logic signed [SW-1:0] s_re, s_im;
  logic [PW-1:0]        den3;
  logic signed [DW:0]   as3_re, as3_im;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld3 <= 1'b0;
    end else if (en) begin
      vld3 <= vld2;
    end
    if (en) begin
      cmd3   <= cmd2;
      as3_re <= as_re;
      as3_im <= as_im;
      den3   <= PW'($unsigned(uu)) + PW'($unsigned(ww));
      if (cmd2 == cna_pkg::CMD_MUL) begin
        s_re <= SW'(xu) - SW'(yw);
        s_im <= SW'(yu) + SW'(xw);
      end else begin
        s_re <= SW'(xu) + SW'(yw);
        s_im <= SW'(yu) - SW'(xw);
      end
    end
  end

  // Stage 4: finish add, subtract and multiply; set up the division
  pipe_t pipe [0:QB];
  pipe_t p0_next;

  always_comb begin
    logic          sr, si;
    logic [SW-1:0] m_re, m_im;
    logic [NW-1:0] n_re, n_im;
    logic [CW-1:0] dtop;
    p0_next     = '0;
    p0_next.vld = vld3;
    p0_next.cmd = cmd3;
    p0_next.den = den3;
    sr = 1'b0;
    si = 1'b0;
    unique case (cmd3)
      cna_pkg::CMD_MUL: begin
        p0_next.res_re = clamp(s_re >>> FB, sr);
        p0_next.res_im = clamp(s_im >>> FB, si);
      end
      cna_pkg::CMD_DIV: begin
      end
      default: begin
        p0_next.res_re = clamp(SW'(as3_re), sr);
        p0_next.res_im = clamp(SW'(as3_im), si);
      end
    endcase
    p0_next.sat    = sr | si;
    p0_next.dz     = (cmd3 == cna_pkg::CMD_DIV) && (den3 == '0);
    m_re           = s_re[SW-1] ? SW'(-s_re) : SW'(s_re);
    m_im           = s_im[SW-1] ? SW'(-s_im) : SW'(s_im);
    n_re           = NW'(m_re) << FB;
    n_im           = NW'(m_im) << FB;
    dtop           = CW'(den3) << QB;
    p0_next.neg_re = s_re[SW-1];
    p0_next.neg_im = s_im[SW-1];
    p0_next.ov_re  = CW'(n_re) >= dtop;
    p0_next.ov_im  = CW'(n_im) >= dtop;
    p0_next.rem_re = n_re;
    p0_next.rem_im = n_im;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pipe[0].vld <= 1'b0;
    end else if (en) begin
      pipe[0] <= p0_next;
    end
  end

  // Divider stages: retire one quotient bit per stage, MSB first
  for (genvar k = 0; k < QB; k++) begin : g_div
    localparam int BIT = QB - 1 - k;
    pipe_t nxt;

    always_comb begin
      logic [CW-1:0] d;
      nxt = pipe[k];
      d   = CW'(pipe[k].den) << BIT;
      if (CW'(pipe[k].rem_re) >= d) begin
        nxt.rem_re    = pipe[k].rem_re - NW'(d);
        nxt.q_re[BIT] = 1'b1;
      end
      if (CW'(pipe[k].rem_im) >= d) begin
        nxt.rem_im    = pipe[k].rem_im - NW'(d);
        nxt.q_im[BIT] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        pipe[k+1].vld <= 1'b0;
      end else if (en) begin
        pipe[k+1] <= nxt;
      end
    end
  end

  // Output stage: saturate the quotients and select the status
  logic signed [DW-1:0] out_re, out_im;
  cna_pkg::status_t     out_st;
  cna_pkg::cmd_t        out_cmd;
  logic signed [DW-1:0] fin_re, fin_im;
  cna_pkg::status_t     fin_st;

  always_comb begin
    logic          sr, si;
    pipe_t         pl;
    pl     = pipe[QB];
    sr     = 1'b0;
    si     = 1'b0;
    fin_re = pl.res_re;
    fin_im = pl.res_im;
    fin_st = pl.sat ? cna_pkg::ST_SAT : cna_pkg::ST_OK;
    if (pl.cmd == cna_pkg::CMD_DIV) begin
      if (pl.dz) begin
        fin_re = '0;
        fin_im = '0;
        fin_st = cna_pkg::ST_DZ;
      end else begin
        fin_re = clamp_q(pl.neg_re, pl.ov_re, pl.q_re, sr);
        fin_im = clamp_q(pl.neg_im, pl.ov_im, pl.q_im, si);
        fin_st = (sr || si) ? cna_pkg::ST_SAT : cna_pkg::ST_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= pipe[QB].vld;
    end
    if (en) begin
      out_re  <= fin_re;
      out_im  <= fin_im;
      out_st  <= fin_st;
      out_cmd <= pipe[QB].cmd;
    end
  end

  assign m_tdata = OTW'({out_im, out_re});
  assign m_tuser = out_st;

`ifndef SYNTH
  // Divide-by-zero only ever comes from a divide
  a_dz_from_div: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_st == cna_pkg::ST_DZ |-> out_cmd == cna_pkg::CMD_DIV)
    else $error("divide-by-zero status on a non-divide word");

  // Divide-by-zero gives zero parts
  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_st == cna_pkg::ST_DZ |-> out_re == '0 && out_im == '0)
    else $error("divide-by-zero word with non-zero parts");

  // Status code three is never produced
  a_status_legal: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> out_st == cna_pkg::ST_OK || out_st == cna_pkg::ST_SAT ||
                 out_st == cna_pkg::ST_DZ)
    else $error("illegal status code");

  // A stall holds the word at the divider tail
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(pipe[QB].vld) && $stable(pipe[QB].q_re))
    else $error("pipeline moved during a stall");
`endif

endmodule

FILE: verif/complex_number_alu_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for complex_number_alu: computes each expected
// result itself and compares it with every word the block returns.
// Depends on cna_pkg and the complex_number_alu RTL.
module complex_number_alu_tb;

  localparam int DW       = 16;
  localparam int FB       = 8;
  localparam int LATENCY  = DW + 6;
  localparam int WD_LIMIT = 20000;

  typedef struct packed {
    logic signed [DW-1:0] re;
    logic signed [DW-1:0] im;
    cna_pkg::status_t     st;
  } cplx_res_t;

  logic          clk;
  logic          rst;
  logic          s_tvalid;
  logic          s_tready;
  logic [63:0]   s_tdata;
  logic [1:0]    s_tuser;
  logic          m_tvalid;
  logic          m_tready;
  logic [31:0]   m_tdata;
  logic [1:0]    m_tuser;

  cplx_res_t     pending_results[$];
  int            mismatches;
  int            idle_cycles;
  int            send_idle_pct;
  int            recv_stall_pct;

  complex_number_alu u_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Clamp a wide signed value to DW bits, flagging saturation
  function automatic logic [DW-1:0] clamp(input logic signed [127:0] v,
                                          inout logic sat);
    logic signed [127:0] hi;
    logic signed [127:0] lo;
    hi = (128'sd1 <<< (DW-1)) - 1;
    lo = -(128'sd1 <<< (DW-1));
    if (v > hi) begin
      sat = 1'b1;
      return hi[DW-1:0];
    end
    if (v < lo) begin
      sat = 1'b1;
      return lo[DW-1:0];
    end
    return v[DW-1:0];
  endfunction

  // Numerator * 2^FB / den, truncated toward zero
  function automatic logic signed [127:0] div_trunc(input logic signed [127:0] num,
                                                    input logic signed [127:0] den);
    logic [127:0] mag;
    logic [127:0] q;
    mag = (num < 0) ? -num : num;
    q = (mag << FB) / den;
    return (num < 0) ? -$signed(q) : $signed(q);
  endfunction

  function automatic cplx_res_t complex_result(input cna_pkg::cmd_t op,
                                               input logic signed [DW-1:0] x,
                                               input logic signed [DW-1:0] y,
                                               input logic signed [DW-1:0] u,
                                               input logic signed [DW-1:0] v);
    cplx_res_t r;
    logic sat;
    logic signed [127:0] wx, wy, wu, wv, den;
    sat = 1'b0;
    wx = x; wy = y; wu = u; wv = v;
    r.st = cna_pkg::ST_OK;
    r.re = '0;
    r.im = '0;
    case (op)
      cna_pkg::CMD_ADD: begin
        r.re = clamp(wx + wu, sat);
        r.im = clamp(wy + wv, sat);
      end
      cna_pkg::CMD_SUB: begin
        r.re = clamp(wx - wu, sat);
        r.im = clamp(wy - wv, sat);
      end
      cna_pkg::CMD_MUL: begin
        r.re = clamp((wx*wu - wy*wv) >>> FB, sat);
        r.im = clamp((wy*wu + wx*wv) >>> FB, sat);
      end
      default: begin
        den = wu*wu + wv*wv;
        if (den == 0) r.st = cna_pkg::ST_DZ;
        else begin
          r.re = clamp(div_trunc(wx*wu + wy*wv, den), sat);
          r.im = clamp(div_trunc(wy*wu - wx*wv, den), sat);
        end
      end
    endcase
    if (r.st == cna_pkg::ST_OK && sat) r.st = cna_pkg::ST_SAT;
    return r;
  endfunction

  // Send one word, holding it until accepted; records the expected result.
  // Valid stays high after acceptance so the next word can follow at once.
  task automatic send_op(input cna_pkg::cmd_t op, input logic [DW-1:0] x,
                         input logic [DW-1:0] y, input logic [DW-1:0] u,
                         input logic [DW-1:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {v, u, y, x};
    s_tuser  <= op;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_results.push_back(complex_result(op, x, y, u, v));
  endtask

  function automatic logic [DW-1:0] rand_operand();
    case ($urandom_range(5))
      0: return DW'(32'h8000 + $urandom_range(3));
      1: return DW'(32'h7fff - $urandom_range(3));
      2: return DW'($urandom_range(32'h0400) - 32'h0200);
      3: return DW'($urandom_range(3));
      default: return DW'($urandom);
    endcase
  endfunction

  task automatic run_random(input int n);
    for (int i = 0; i < n; i++)
      send_op(cna_pkg::cmd_t'($urandom_range(3)), rand_operand(), rand_operand(),
              rand_operand(), rand_operand());
  endtask

  // Drop valid and hold until every expected word has come back
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    cna_pkg::cmd_t op;
    op = cna_pkg::CMD_ADD;
    send_op(cna_pkg::CMD_ADD, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
    send_op(cna_pkg::CMD_ADD, 16'h0100, 16'hff00, 16'h0080, 16'h0040);
    send_op(cna_pkg::CMD_SUB, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
    send_op(cna_pkg::CMD_SUB, 16'h0000, 16'h0000, 16'h8000, 16'h0001);
    send_op(cna_pkg::CMD_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_op(cna_pkg::CMD_MUL, 16'h7fff, 16'h7fff, 16'h7fff, 16'h8000);
    send_op(cna_pkg::CMD_MUL, 16'hffff, 16'h0000, 16'h0001, 16'h0000);
    send_op(cna_pkg::CMD_MUL, 16'h0100, 16'h0100, 16'h0100, 16'hff00);
    send_op(cna_pkg::CMD_DIV, 16'h1234, 16'h8000, 16'h0000, 16'h0000);
    send_op(cna_pkg::CMD_DIV, 16'h7fff, 16'h7fff, 16'h0001, 16'h0000);
    send_op(cna_pkg::CMD_DIV, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_op(cna_pkg::CMD_DIV, 16'h0100, 16'h0000, 16'h0000, 16'h0100);
    send_op(cna_pkg::CMD_DIV, 16'hff00, 16'h0100, 16'h7fff, 16'h8000);
    send_op(cna_pkg::CMD_DIV, 16'h0001, 16'hffff, 16'h0003, 16'h0000);
    send_op(cna_pkg::CMD_DIV, 16'hffff, 16'hffff, 16'hffff, 16'h0001);
    send_op(op, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
  endtask

  task automatic test_full_rate();
    send_idle_pct = 0; recv_stall_pct = 0;
    run_random(400);
  endtask

  task automatic test_sender_gaps();
    send_idle_pct = 72; recv_stall_pct = 0;
    run_random(400);
    // pause until the pipe is empty, then go on
    wait_drained();
    run_random(20);
  endtask

  task automatic test_receiver_stalls();
    send_idle_pct = 0; recv_stall_pct = 72;
    run_random(400);
  endtask

  task automatic test_both_idle();
    send_idle_pct = 23; recv_stall_pct = 23;
    run_random(410);
  endtask

  // Receiver back-pressure
  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Compare each returned word with the oldest expectation
  always @(posedge clk) begin
    cplx_res_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %h/%0d", m_tdata, m_tuser);
      end else begin
        want = pending_results.pop_front();
        if (m_tdata[DW-1:0] !== want.re || m_tdata[2*DW-1:DW] !== want.im ||
            m_tuser !== want.st) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: want re %h im %h st %0d, got re %h im %h st %0d",
                     want.re, want.im, want.st, m_tdata[DW-1:0], m_tdata[2*DW-1:DW],
                     m_tuser);
        end
      end
    end
  end

  // Watchdog on cycles with no accepted word
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WD_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    mismatches = 0;
    idle_cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_full_rate();
    test_sender_gaps();
    test_receiver_stalls();
    test_both_idle();
    wait_drained();
    repeat (LATENCY + 4) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
